FILE: rtl/ppc_pkg.sv
// Shared types and constants for the polygon plane clipper.
// Used by the interfaces, the multiply-accumulate unit, the divider and the top level.
package ppc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NORM_W          = 18;
    localparam int MARGIN_W        = 16;
    localparam int DIST_W          = 40;
    localparam int DEN_W           = DIST_W + 1;
    localparam int T_FRAC          = 16;
    localparam int T_W             = T_FRAC + 1;
    localparam int CHUNK_W         = 16;
    localparam int MUL_A_W         = NORM_W;
    localparam int MUL_B_W         = CHUNK_W + 1;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int SHIFT_W         = 2;
    localparam int COUNT_W         = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int SURVIVE_MIN     = 3;

    localparam logic [T_W-1:0]     T_ONE     = 17'h10000;
    localparam logic [T_W-1:0]     T_HALF    = 17'h08000;
    localparam logic [T_W-1:0]     T_ZERO    = 17'h00000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_PX,
        REG_PLANE_PY,
        REG_PLANE_PZ,
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_KEEP_MARGIN
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_KEEP = 2'd0,
        KIND_CUT  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef struct packed {
        logic                 clear;
        logic                 issue;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
        logic [SHIFT_W-1:0]   shift;
    } t_mac_req;

endpackage

FILE: rtl/ppc_vert_if.sv
// Vertex input channel of the polygon plane clipper.
// Depends on ppc_pkg for the default coordinate width.
interface ppc_vert_if #(
    parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [COORD_WIDTH-1:0] vert_z;
    logic                          poly_last;

    modport source (output valid, vert_x, vert_y, vert_z, poly_last, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, poly_last, output ready);
endinterface

FILE: rtl/ppc_res_if.sv
// Result output channel of the polygon plane clipper.
// Depends on ppc_pkg for the default coordinate width and the count width.
interface ppc_res_if #(
    parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [COORD_WIDTH-1:0]      out_x;
    logic signed [COORD_WIDTH-1:0]      out_y;
    logic signed [COORD_WIDTH-1:0]      out_z;
    logic [1:0]                         item_kind;
    logic [ppc_pkg::COUNT_W-1:0]        vertex_total;
    logic                               survives;
    logic                               run_end;

    modport source (output valid, out_x, out_y, out_z, item_kind, vertex_total, survives,
                    run_end, input ready);
    modport sink   (input valid, out_x, out_y, out_z, item_kind, vertex_total, survives,
                    run_end, output ready);
endinterface

FILE: rtl/polygon_plane_clipper_core.sv
// Polygon plane clipper: one clipping pass of a vertex loop against a half-space.
// Each vertex's distance takes one MAC pass per axis over the coordinate chunks, then an edge
// test and a result; a crossing point takes a division in the divider and then an
// interpolation per axis through the same MAC.
// Input ready is high only while idle; the output register lets the last result wait.
// Reset is synchronous and active low: registers return to their reset values, polygon cleared.
module polygon_plane_clipper_core #(
    parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [(COORD_WIDTH > ppc_pkg::NORM_W ? COORD_WIDTH : ppc_pkg::NORM_W)-1:0]
                                                            i_cfg_wdata,
    ppc_vert_if.sink                                        i_vert,
    ppc_res_if.source                                       o_res
);

    localparam int CFG_W  = (COORD_WIDTH > ppc_pkg::NORM_W) ? COORD_WIDTH : ppc_pkg::NORM_W;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int NCH    = (DIFF_W + ppc_pkg::CHUNK_W - 1) / ppc_pkg::CHUNK_W;
    localparam int PAD_W  = NCH * ppc_pkg::CHUNK_W;
    localparam int CHK_W  = $clog2(NCH);
    localparam int ACC_W  = DIFF_W + ppc_pkg::NORM_W + 2;
    localparam int FULL_W = ACC_W - ppc_pkg::T_FRAC;
    localparam int WIDE_W = (FULL_W > ppc_pkg::DIST_W) ? FULL_W : ppc_pkg::DIST_W;
    localparam int DW     = ppc_pkg::DIST_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_DRAIN,
        S_DIST,
        S_EDGE,
        S_KEEP,
        S_DEN,
        S_ABS,
        S_DIVCHK,
        S_DIV,
        S_LAX,
        S_LOUT,
        S_END
    } t_state;

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0]      r_plane [3];
    logic signed [ppc_pkg::NORM_W-1:0]  r_norm [3];
    logic [ppc_pkg::MARGIN_W-1:0]       r_margin;

    // Sequencer and polygon state.
    t_state                             r_state;
    t_state                             n_after_edge;
    logic signed [COORD_WIDTH-1:0]      r_cur [3];
    logic signed [COORD_WIDTH-1:0]      r_prev [3];
    logic signed [COORD_WIDTH-1:0]      r_first [3];
    logic signed [COORD_WIDTH-1:0]      r_cut [3];
    logic signed [DW-1:0]               r_cur_d;
    logic signed [DW-1:0]               r_prev_d;
    logic signed [DW-1:0]               r_first_d;
    logic                               r_last;
    logic                               r_seen;
    logic [ppc_pkg::COUNT_W-1:0]        r_count;
    logic                               r_edge;
    logic                               r_lerp;
    logic [1:0]                         r_axis;
    logic [CHK_W-1:0]                   r_chunk;
    logic signed [DIFF_W-1:0]           r_diff;
    logic                               r_ain;
    logic                               r_bin;
    logic signed [ppc_pkg::DEN_W-1:0]   r_den;
    logic [ppc_pkg::DEN_W-1:0]          r_an;
    logic [ppc_pkg::DEN_W-1:0]          r_ad;
    logic [ppc_pkg::T_W-1:0]            r_t;

    // Output register.
    logic                               r_ovalid;
    logic signed [COORD_WIDTH-1:0]      r_out_x;
    logic signed [COORD_WIDTH-1:0]      r_out_y;
    logic signed [COORD_WIDTH-1:0]      r_out_z;
    ppc_pkg::t_kind                     r_out_kind;
    logic [ppc_pkg::COUNT_W-1:0]        r_out_total;
    logic                               r_out_surv;
    logic                               r_out_end;

    // Combinational helpers.
    logic signed [COORD_WIDTH-1:0]      w_ea [3];
    logic signed [COORD_WIDTH-1:0]      w_eb [3];
    logic signed [DW-1:0]               w_ea_d;
    logic signed [DW-1:0]               w_eb_d;
    logic                               w_a_keep;
    logic                               w_b_keep;
    logic signed [DIFF_W-1:0]           w_diff;
    logic signed [PAD_W-1:0]            w_pad;
    logic [ppc_pkg::CHUNK_W-1:0]        w_chunk;
    logic                               w_top;
    logic signed [ACC_W-1:0]            w_acc;
    logic signed [WIDE_W-1:0]           w_wide;
    logic [WIDE_W-DW:0]                 w_upper;
    logic signed [DW-1:0]               w_dist;
    logic signed [COORD_WIDTH-1:0]      w_lerp_v;
    logic signed [ppc_pkg::DEN_W-1:0]   w_da_ext;
    logic                               w_out_free;
    logic                               w_div_start;
    logic                               w_div_busy;
    logic [ppc_pkg::T_FRAC-1:0]         w_quot;
    logic [ppc_pkg::COUNT_W-1:0]        w_count_inc;
    ppc_pkg::t_mac_req                  w_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane[0] <= '0;
            r_plane[1] <= '0;
            r_plane[2] <= '0;
            r_norm[0]  <= '0;
            r_norm[1]  <= '0;
            r_norm[2]  <= 18'sh10000;
            r_margin   <= 16'd1;
        end else if (i_cfg_we) begin
            case (ppc_pkg::t_cfg_reg'(i_cfg_idx))
                ppc_pkg::REG_PLANE_PX:    r_plane[0] <= COORD_WIDTH'(i_cfg_wdata);
                ppc_pkg::REG_PLANE_PY:    r_plane[1] <= COORD_WIDTH'(i_cfg_wdata);
                ppc_pkg::REG_PLANE_PZ:    r_plane[2] <= COORD_WIDTH'(i_cfg_wdata);
                ppc_pkg::REG_NORMAL_X:    r_norm[0]  <= ppc_pkg::NORM_W'(i_cfg_wdata);
                ppc_pkg::REG_NORMAL_Y:    r_norm[1]  <= ppc_pkg::NORM_W'(i_cfg_wdata);
                ppc_pkg::REG_NORMAL_Z:    r_norm[2]  <= ppc_pkg::NORM_W'(i_cfg_wdata);
                ppc_pkg::REG_KEEP_MARGIN: r_margin   <= ppc_pkg::MARGIN_W'(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ea[i] = r_edge ? r_cur[i] : r_prev[i];
            w_eb[i] = r_edge ? r_first[i] : r_cur[i];
        end
        w_ea_d   = r_edge ? r_cur_d : r_prev_d;
        w_eb_d   = r_edge ? r_first_d : r_cur_d;
        w_a_keep = (w_ea_d <= $signed({1'b0, r_margin}));
        w_b_keep = (w_eb_d <= $signed({1'b0, r_margin}));

        if (r_lerp) begin
            w_diff = DIFF_W'(w_eb[r_axis]) - DIFF_W'(w_ea[r_axis]);
        end else begin
            w_diff = DIFF_W'(r_cur[r_axis]) - DIFF_W'(r_plane[r_axis]);
        end

        w_pad   = PAD_W'(r_diff);
        w_chunk = w_pad[r_chunk * ppc_pkg::CHUNK_W +: ppc_pkg::CHUNK_W];
        w_top   = (r_chunk == CHK_W'(NCH - 1));

        w_mac.issue = (r_state == S_MUL);
        w_mac.clear = (r_state == S_DIFF) && (r_lerp || (r_axis == 2'd0));
        w_mac.a     = r_lerp ? ppc_pkg::MUL_A_W'(r_t) : r_norm[r_axis];
        w_mac.b     = {w_top & w_chunk[ppc_pkg::CHUNK_W-1], w_chunk};
        w_mac.shift = ppc_pkg::SHIFT_W'(r_chunk);

        // The floored distance saturates to the stored width.
        w_wide  = WIDE_W'($signed(w_acc[ACC_W-1:ppc_pkg::T_FRAC]));
        w_upper = w_wide[WIDE_W-1:DW-1];
        if ((&w_upper) || !(|w_upper)) begin
            w_dist = w_wide[DW-1:0];
        end else if (w_wide[WIDE_W-1]) begin
            w_dist = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_dist = {1'b0, {(DW-1){1'b1}}};
        end

        w_lerp_v = w_ea[r_axis] + $signed(w_acc[ppc_pkg::T_FRAC +: COORD_WIDTH]);
        w_da_ext = ppc_pkg::DEN_W'(w_ea_d);

        w_out_free  = !r_ovalid || o_res.ready;
        w_div_start = (r_state == S_DIVCHK) && (r_den != '0) && (w_ea_d != '0)
                      && (w_ea_d[DW-1] == r_den[ppc_pkg::DEN_W-1]) && (r_an < r_ad);
        w_count_inc = (r_count == ppc_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;

        if (!r_edge && r_last) begin
            n_after_edge = S_EDGE;
        end else if (r_last) begin
            n_after_edge = S_END;
        end else begin
            n_after_edge = S_IDLE;
        end
    end

    ppc_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac),
        .o_acc   (w_acc)
    );

    ppc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_an),
        .i_den   (r_ad),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_seen   <= 1'b0;
            r_count  <= '0;
        end else begin
            if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_vert.valid) begin
                        r_prev   <= r_cur;
                        r_prev_d <= r_cur_d;
                        r_cur[0] <= i_vert.vert_x;
                        r_cur[1] <= i_vert.vert_y;
                        r_cur[2] <= i_vert.vert_z;
                        r_last   <= i_vert.poly_last;
                        r_lerp   <= 1'b0;
                        r_axis   <= 2'd0;
                        r_state  <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_diff  <= w_diff;
                    r_chunk <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_chunk == CHK_W'(NCH - 1)) begin
                        if (!r_lerp && (r_axis != 2'd2)) begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_DIFF;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= r_lerp ? S_LAX : S_DIST;
                end
                S_DIST: begin
                    r_cur_d <= w_dist;
                    if (!r_seen) begin
                        r_first   <= r_cur;
                        r_first_d <= w_dist;
                        r_seen    <= 1'b1;
                    end
                    if (r_seen) begin
                        r_edge  <= 1'b0;
                        r_state <= S_EDGE;
                    end else if (r_last) begin
                        r_edge  <= 1'b1;
                        r_state <= S_EDGE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EDGE: begin
                    r_ain <= w_a_keep;
                    r_bin <= w_b_keep;
                    if (w_a_keep) begin
                        r_state <= S_KEEP;
                    end else if (w_b_keep) begin
                        r_state <= S_DEN;
                    end else begin
                        r_edge  <= 1'b1;
                        r_state <= n_after_edge;
                    end
                end
                S_KEEP: begin
                    if (w_out_free) begin
                        r_ovalid    <= 1'b1;
                        r_out_x     <= w_ea[0];
                        r_out_y     <= w_ea[1];
                        r_out_z     <= w_ea[2];
                        r_out_kind  <= ppc_pkg::KIND_KEEP;
                        r_out_total <= '0;
                        r_out_surv  <= 1'b0;
                        r_out_end   <= !r_last && (r_ain == r_bin);
                        r_count     <= w_count_inc;
                        if (r_ain != r_bin) begin
                            r_state <= S_DEN;
                        end else begin
                            r_edge  <= 1'b1;
                            r_state <= n_after_edge;
                        end
                    end
                end
                S_DEN: begin
                    r_den   <= w_da_ext - ppc_pkg::DEN_W'(w_eb_d);
                    r_an    <= w_da_ext[ppc_pkg::DEN_W-1] ? -w_da_ext : w_da_ext;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_ad    <= r_den[ppc_pkg::DEN_W-1] ? -r_den : r_den;
                    r_state <= S_DIVCHK;
                end
                S_DIVCHK: begin
                    r_lerp <= 1'b1;
                    r_axis <= 2'd0;
                    priority if (r_den == '0) begin
                        r_t     <= ppc_pkg::T_HALF;
                        r_state <= S_DIFF;
                    end else if (w_ea_d == '0) begin
                        r_t     <= ppc_pkg::T_ZERO;
                        r_state <= S_DIFF;
                    end else if (w_ea_d[DW-1] != r_den[ppc_pkg::DEN_W-1]) begin
                        r_t     <= ppc_pkg::T_ZERO;
                        r_state <= S_DIFF;
                    end else if (r_an >= r_ad) begin
                        r_t     <= ppc_pkg::T_ONE;
                        r_state <= S_DIFF;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_t     <= {1'b0, w_quot};
                        r_state <= S_DIFF;
                    end
                end
                S_LAX: begin
                    r_cut[r_axis] <= w_lerp_v;
                    if (r_axis == 2'd2) begin
                        r_state <= S_LOUT;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_DIFF;
                    end
                end
                S_LOUT: begin
                    if (w_out_free) begin
                        r_ovalid    <= 1'b1;
                        r_out_x     <= r_cut[0];
                        r_out_y     <= r_cut[1];
                        r_out_z     <= r_cut[2];
                        r_out_kind  <= ppc_pkg::KIND_CUT;
                        r_out_total <= '0;
                        r_out_surv  <= 1'b0;
                        r_out_end   <= !r_last;
                        r_count     <= w_count_inc;
                        r_edge      <= 1'b1;
                        r_state     <= n_after_edge;
                    end
                end
                S_END: begin
                    if (w_out_free) begin
                        r_ovalid    <= 1'b1;
                        r_out_x     <= '0;
                        r_out_y     <= '0;
                        r_out_z     <= '0;
                        r_out_kind  <= ppc_pkg::KIND_END;
                        r_out_total <= r_count;
                        r_out_surv  <= (r_count >= ppc_pkg::COUNT_W'(ppc_pkg::SURVIVE_MIN));
                        r_out_end   <= 1'b1;
                        r_seen      <= 1'b0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_vert.ready       = (r_state == S_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.out_x        = r_out_x;
    assign o_res.out_y        = r_out_y;
    assign o_res.out_z        = r_out_z;
    assign o_res.item_kind    = r_out_kind;
    assign o_res.vertex_total = r_out_total;
    assign o_res.survives     = r_out_surv;
    assign o_res.run_end      = r_out_end;

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_count == '0))
        else $error("Emitted count is non-zero with no polygon open.");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("Divider started while still busy.");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.item_kind == ppc_pkg::KIND_END)) |-> o_res.run_end)
        else $error("End item is not marked as the final transfer of its vertex.");

    a_cut_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOUT) |-> r_seen)
        else $error("Cut point produced outside an open polygon.");

endmodule

FILE: rtl/ppc_mac.sv
// Shared multiply-accumulate unit: a registered 18 by 17 bit product is shifted
// by whole chunks and added into a wide accumulator. Depends on ppc_pkg.
module ppc_mac #(
    parameter int ACC_W = 53
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ppc_pkg::t_mac_req       i_req,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [ppc_pkg::PROD_W-1:0]  r_prod;
    logic [ppc_pkg::SHIFT_W-1:0]        r_shift;
    logic                               r_pvalid;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [ACC_W-1:0]            w_term;

    always_comb begin
        w_term = ACC_W'(r_prod) <<< (ppc_pkg::CHUNK_W * int'(r_shift));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_req.issue;
        end
        r_prod  <= $signed(i_req.a) * $signed(i_req.b);
        r_shift <= i_req.shift;
        if (i_req.clear) begin
            r_acc <= '0;
        end else if (r_pvalid) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/ppc_div.sv
// Restoring divider giving a 16-bit fraction of two unsigned magnitudes,
// one quotient bit per cycle; the numerator must be below the denominator. Depends on ppc_pkg.
module ppc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ppc_pkg::DEN_W-1:0]   i_num,
    input  logic [ppc_pkg::DEN_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [ppc_pkg::T_FRAC-1:0]  o_quot
);

    localparam int CNT_W = $clog2(ppc_pkg::T_FRAC);

    logic                           r_busy;
    logic [CNT_W-1:0]               r_cnt;
    logic [ppc_pkg::DEN_W-1:0]      r_rem;
    logic [ppc_pkg::DEN_W-1:0]      r_den;
    logic [ppc_pkg::T_FRAC-1:0]     r_quot;
    logic [ppc_pkg::DEN_W:0]        w_shift;
    logic [ppc_pkg::DEN_W:0]        w_diff;
    logic                           w_ge;

    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = !w_diff[ppc_pkg::DEN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[ppc_pkg::DEN_W-1:0] : w_shift[ppc_pkg::DEN_W-1:0];
            r_quot <= {r_quot[ppc_pkg::T_FRAC-2:0], w_ge};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ppc_pkg::T_FRAC - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
